// File: hw/rtl/t2enc_pkg.sv
// Shared types, form codes and helpers for the Thumb-2 encoder.
package t2enc_pkg;

  typedef enum logic [5:0] {
    CMD_ADC_LO = 6'd0, CMD_ADD_IMM = 6'd1, CMD_ADD_SHREG = 6'd2, CMD_AND_IMM = 6'd3,
    CMD_AND_SHREG = 6'd4, CMD_ASR_IMM = 6'd5, CMD_ASR_REG = 6'd6, CMD_B_COND = 6'd7,
    CMD_B = 6'd8, CMD_BIC_IMM = 6'd9, CMD_BIC_SHREG = 6'd10, CMD_BL = 6'd11,
    CMD_BLX = 6'd12, CMD_BX = 6'd13, CMD_CMP_IMM = 6'd14, CMD_CMP_REG = 6'd15,
    CMD_EOR_IMM = 6'd16, CMD_EOR_SHREG = 6'd17, CMD_LDM = 6'd18, CMD_LDR_IMM = 6'd19,
    CMD_LDR_LIT = 6'd20, CMD_LDR_REG = 6'd21, CMD_LDRB_IMM = 6'd22,
    CMD_LDRH_IMM = 6'd23, CMD_LDRH_REG = 6'd24, CMD_LSL_IMM = 6'd25,
    CMD_LSL_REG = 6'd26, CMD_LSR_IMM = 6'd27, CMD_LSR_REG = 6'd28,
    CMD_MOV_IMM = 6'd29, CMD_MOV_REG = 6'd30, CMD_MOVT = 6'd31, CMD_MRS = 6'd32,
    CMD_MSR = 6'd33, CMD_MVN_IMM = 6'd34, CMD_MVN_SHREG = 6'd35, CMD_NOP = 6'd36,
    CMD_ORR_IMM = 6'd37, CMD_ORR_SHREG = 6'd38, CMD_POP_N = 6'd39, CMD_POP = 6'd40,
    CMD_PUSH_N = 6'd41, CMD_PUSH = 6'd42, CMD_ROR_IMM = 6'd43, CMD_ROR_REG = 6'd44,
    CMD_STR_IMM = 6'd45, CMD_STR_REG = 6'd46, CMD_STRB_IMM = 6'd47,
    CMD_STRH_IMM = 6'd48, CMD_STRH_REG = 6'd49, CMD_SBC = 6'd50, CMD_SUB_IMM = 6'd51,
    CMD_SUB_SHREG = 6'd52, CMD_SXTB = 6'd53, CMD_SXTH = 6'd54, CMD_TST = 6'd55,
    CMD_UXTB = 6'd56, CMD_UXTH = 6'd57, CMD_DATA = 6'd58
  } cmd_t;

  // Request as captured by the front end.
  typedef struct packed {
    logic [5:0]         cmd;
    logic [3:0]         rd;
    logic [3:0]         rn;
    logic [3:0]         rm;
    logic signed [32:0] imm;
    logic               set_flags;
    logic [1:0]         shift_type;
    logic [5:0]         shift_amount;
    logic [3:0]         cond;
    logic [15:0]        reg_list;
    logic               flag_bit;
  } req_t;

  // Encoded instruction handed to the back end.
  typedef struct packed {
    logic [15:0] hw0;
    logic [15:0] hw1;
    logic        two;
    logic        bad;
  } enc_t;

  // Result of the modified-immediate search: ok, 32-bit field pattern.
  typedef struct packed {
    logic        ok;
    logic [31:0] e;
  } mi_t;

  function automatic logic [4:0] ctz32(input logic [31:0] v);
    logic [4:0] k;
    k = 5'd31;
    for (int i = 30; i >= 0; i--) begin
      if (v[i]) k = 5'(i);
    end
    return k;
  endfunction

  function automatic mi_t mi_try(input logic [31:0] v);
    mi_t        r;
    logic [4:0] tz;
    logic [31:0] w;
    logic [4:0] top;
    logic [4:0] sh;
    logic [5:0] rot;
    r.ok = 1'b1;
    r.e  = '0;
    tz   = ctz32(v);
    w    = v >> tz;
    top  = tz;
    for (int i = 1; i < 8; i++) begin
      if (w[i]) top = tz + 5'(i);
    end
    sh  = top - 5'd7;
    rot = 6'd32 - {1'b0, sh};
    if (v <= 32'hFF) begin
      r.e = v;
    end else if (v[15:0] == v[31:16] && v[15:8] == 8'h0) begin
      r.e = 32'h1000 | {24'h0, v[7:0]};
    end else if (v[15:0] == v[31:16] && v[7:0] == 8'h0) begin
      r.e = 32'h2000 | {24'h0, v[15:8]};
    end else if (v[15:0] == v[31:16] && v[7:0] == v[15:8]) begin
      r.e = 32'h3000 | {24'h0, v[7:0]};
    end else if (w > 32'hFF) begin
      r.ok = 1'b0;
    end else begin
      r.e = ({31'h0, rot[4]} << 26) | ({29'h0, rot[3:1]} << 12) |
            ({31'h0, rot[0]} << 7) | ({25'h0, 7'((v >> sh) & 32'h7F)});
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/t2enc_front.sv
// Front end: accepts requests and computes the encoding into a two-entry queue.
module t2enc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  t2enc_pkg::req_t   req,
  output logic              q_valid,
  input  logic              q_ready,
  output t2enc_pkg::enc_t   q_data
);
  import t2enc_pkg::*;

  enc_t       enc;
  enc_t       q_mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  t2enc_enc u_enc (.req(req), .enc(enc));

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= enc;
  end

endmodule

// File: hw/rtl/t2enc_enc.sv
// Combinational encoder: one request to one or two halfwords and an error flag.
module t2enc_enc (
  input  t2enc_pkg::req_t req,
  output t2enc_pkg::enc_t enc
);
  import t2enc_pkg::*;

  logic [31:0] d, n, m, u, sh, ty, s, rl, fb, cnd;
  logic signed [33:0] si;
  logic lsl0;
  mi_t  mi;
  logic [31:0] e;
  logic [31:0] h0, h1;
  logic two, bad;
  logic [31:0] shvf;
  logic [31:0] a5;
  logic [31:0] w;

  function automatic logic [31:0] br(input logic signed [33:0] v, input logic [31:0] base,
                                     input logic [31:0] mask);
    logic signed [33:0] t;
    t = v - 34'sd2;
    if (t < 0) t = t - 34'sd2;
    return base | (32'(t >>> 1) & mask);
  endfunction

  always_comb begin
    logic signed [33:0] off, ab;
    logic neg, j1, j2;
    d  = {28'h0, req.rd};
    n  = {28'h0, req.rn};
    m  = {28'h0, req.rm};
    u  = req.imm[31:0];
    si = 34'(req.imm);
    sh = {26'h0, req.shift_amount};
    ty = {30'h0, req.shift_type};
    s  = {31'h0, req.set_flags};
    rl = {16'h0, req.reg_list};
    fb = {31'h0, req.flag_bit};
    cnd = {28'h0, req.cond};
    lsl0 = (ty == 0) && (sh == 0);
    mi = mi_try(u);
    e  = mi.ok ? mi.e : 32'h0;
    shvf = ({27'h0, sh[4:2]} << 12) | ({30'h0, sh[1:0]} << 6) | (ty << 4);
    a5 = {27'h0, sh[4:0]};
    w  = {16'h0, u[15:0]};
    off = '0; ab = '0; neg = 1'b0; j1 = 1'b0; j2 = 1'b0;
    h0 = '0; h1 = '0; two = 1'b0; bad = 1'b0;
    case (req.cmd)
      CMD_ADC_LO, CMD_SBC, CMD_SXTB, CMD_SXTH, CMD_UXTB, CMD_UXTH: begin
        bad = d > 7 || m > 7;
        case (req.cmd)
          CMD_ADC_LO: h0 = 32'h4140;
          CMD_SBC:    h0 = 32'h4180;
          CMD_SXTB:   h0 = 32'hB240;
          CMD_SXTH:   h0 = 32'hB200;
          CMD_UXTB:   h0 = 32'hB2C0;
          default:    h0 = 32'hB280;
        endcase
        h0 = h0 | ((m & 7) << 3) | (d & 7);
      end
      CMD_ADD_IMM, CMD_AND_IMM, CMD_BIC_IMM, CMD_EOR_IMM, CMD_ORR_IMM, CMD_SUB_IMM: begin
        two = 1'b1; bad = !mi.ok;
        case (req.cmd)
          CMD_ADD_IMM: h0 = 32'hF100;
          CMD_AND_IMM: h0 = 32'hF000;
          CMD_BIC_IMM: h0 = 32'hF020;
          CMD_EOR_IMM: h0 = 32'hF080;
          CMD_ORR_IMM: h0 = 32'hF040;
          default:     h0 = 32'hF1A0;
        endcase
        h0 = h0 | (s << 4) | (e >> 16) | n;
        h1 = (e & 32'hFFFF) | (d << 8);
        if (req.cmd == CMD_ADD_IMM && s[0] && d < 8 && n < 8) begin
          if (d == n && u <= 32'hFF) begin
            two = 1'b0; bad = 1'b0; h0 = 32'h3000 | (d << 8) | u;
          end else if (u <= 7) begin
            two = 1'b0; bad = 1'b0; h0 = 32'h1C00 | (u << 6) | (n << 3) | d;
          end
        end
        if (req.cmd == CMD_SUB_IMM && s[0] && d < 8 && n == d && u <= 32'hFF) begin
          two = 1'b0; bad = 1'b0; h0 = 32'h3800 | (d << 8) | u;
        end
      end
      CMD_ADD_SHREG, CMD_SUB_SHREG, CMD_AND_SHREG, CMD_BIC_SHREG, CMD_EOR_SHREG,
      CMD_ORR_SHREG, CMD_MVN_SHREG: begin
        two = 1'b1; bad = sh > 31;
        case (req.cmd)
          CMD_ADD_SHREG: h0 = 32'hEB00 | n;
          CMD_SUB_SHREG: h0 = 32'hEBA0 | n;
          CMD_AND_SHREG: h0 = 32'hEA00 | n;
          CMD_BIC_SHREG: h0 = 32'hEA20 | n;
          CMD_EOR_SHREG: h0 = 32'hEA80 | n;
          CMD_ORR_SHREG: h0 = 32'hEA40 | n;
          default:       h0 = 32'hEA6F;
        endcase
        h0 = h0 | (s << 4);
        h1 = shvf | (d << 8) | m;
        if (lsl0) begin
          case (req.cmd)
            CMD_ADD_SHREG: begin
              if (!s[0] && d == n) begin
                two = 1'b0; h0 = 32'h4400 | ((d & 8) << 4) | (m << 3) | (d & 7);
              end else if (s[0] && d < 8 && n < 8 && m < 8) begin
                two = 1'b0; h0 = 32'h1800 | (m << 6) | (n << 3) | d;
              end
            end
            CMD_SUB_SHREG: begin
              if (s[0] && d < 8 && n < 8 && m < 8) begin
                two = 1'b0; h0 = 32'h1A00 | (m << 6) | (n << 3) | d;
              end
            end
            CMD_MVN_SHREG: begin
              if (s[0] && d < 8 && m < 8) begin
                two = 1'b0; h0 = 32'h43C0 | (m << 3) | d;
              end
            end
            default: begin
              if (s[0] && d < 8 && n == d && m < 8) begin
                two = 1'b0;
                case (req.cmd)
                  CMD_AND_SHREG: h0 = 32'h4000;
                  CMD_BIC_SHREG: h0 = 32'h4380;
                  CMD_EOR_SHREG: h0 = 32'h4040;
                  default:       h0 = 32'h4300;
                endcase
                h0 = h0 | (m << 3) | d;
              end
            end
          endcase
        end
      end
      CMD_ASR_IMM, CMD_LSL_IMM, CMD_LSR_IMM, CMD_ROR_IMM: begin
        case (req.cmd)
          CMD_ASR_IMM: begin bad = !(sh >= 1 && sh <= 32); h0 = 32'h1000; h1 = 2; end
          CMD_LSL_IMM: begin bad = sh > 31; h0 = 32'h0000; h1 = 0; end
          CMD_LSR_IMM: begin bad = !(sh >= 1 && sh <= 32); h0 = 32'h0800; h1 = 1; end
          default:     begin bad = !(sh >= 1 && sh <= 31); h0 = 32'h0; h1 = 3; end
        endcase
        if (req.cmd != CMD_ROR_IMM && s[0] && d < 8 && m < 8) begin
          h0 = h0 | (a5 << 6) | (m << 3) | d;
        end else begin
          two = 1'b1;
          h0 = 32'hEA4F | (s << 4);
          h1 = (h1 << 4) | ((a5 >> 2) << 12) | (d << 8) | ((a5 & 3) << 6) | m;
        end
      end
      CMD_ASR_REG, CMD_LSL_REG, CMD_LSR_REG, CMD_ROR_REG: begin
        if (s[0] && d < 8 && n == d && m < 8) begin
          case (req.cmd)
            CMD_ASR_REG: h0 = 32'h4100;
            CMD_LSL_REG: h0 = 32'h4080;
            CMD_LSR_REG: h0 = 32'h40C0;
            default:     h0 = 32'h41C0;
          endcase
          h0 = h0 | (m << 3) | d;
        end else begin
          two = 1'b1;
          case (req.cmd)
            CMD_ASR_REG: h0 = 32'hFA40;
            CMD_LSL_REG: h0 = 32'hFA00;
            CMD_LSR_REG: h0 = 32'hFA20;
            default:     h0 = 32'hFA60;
          endcase
          h0 = h0 | (s << 4) | n;
          h1 = 32'hF000 | (d << 8) | m;
        end
      end
      CMD_B_COND: begin
        bad = cnd >= 14 || si < -34'sd252 || si > 34'sd256;
        h0 = br(si, 32'hD000 | (cnd << 8), 32'hFF);
      end
      CMD_B: begin
        bad = si < -34'sd2044 || si > 34'sd2048;
        h0 = br(si, 32'hE000, 32'h7FF);
      end
      CMD_BL: begin
        two = 1'b1;
        off = si;
        if (off < 0) off = off - 34'sd4;
        neg = off < 0;
        j2 = off[22];
        j1 = off[23];
        if (!neg) begin j1 = ~j1; j2 = ~j2; end
        h0 = 32'hF000 | ({31'h0, neg} << 10) | {22'h0, off[21:12]};
        h1 = 32'hD000 | ({31'h0, j1} << 13) | ({31'h0, j2} << 11) | {21'h0, off[11:1]};
      end
      CMD_BLX: h0 = 32'h4780 | (m << 3);
      CMD_BX:  h0 = 32'h4700 | (m << 3);
      CMD_CMP_IMM: begin
        if (n < 8 && u <= 32'hFF) begin
          h0 = 32'h2800 | (n << 8) | u;
        end else begin
          two = 1'b1; bad = !mi.ok;
          h0 = 32'hF1B0 | (e >> 16) | n;
          h1 = 32'h0F00 | (e & 32'hFFFF);
        end
      end
      CMD_CMP_REG: begin
        if (m < 8 && n < 8) h0 = 32'h4280 | (m << 3) | n;
        else h0 = 32'h4500 | ((n & 8) << 4) | (m << 3) | (n & 7);
      end
      CMD_LDM: begin
        two = 1'b1;
        bad = rl[13] || rl[15:14] == 2'b11;
        h0 = 32'hE890 | (fb << 5) | n;
        h1 = rl;
      end
      CMD_LDR_IMM, CMD_STR_IMM: begin
        if (d < 8 && n < 8 && (u & 32'hFFFFFF83) == 0) begin
          h0 = (req.cmd == CMD_LDR_IMM ? 32'h6800 : 32'h6000) | ((u >> 2) << 6) |
               (n << 3) | d;
        end else if (d < 8 && n == 13 && u <= 1020 && u[1:0] == 2'b0) begin
          h0 = (req.cmd == CMD_LDR_IMM ? 32'h9800 : 32'h9000) | (d << 8) | (u >> 2);
        end else begin
          two = 1'b1;
          bad = (req.cmd == CMD_LDR_IMM && n == 15) || u > 4095;
          h0 = (req.cmd == CMD_LDR_IMM ? 32'hF8D0 : 32'hF8C0) | n;
          h1 = (d << 12) | (u & 32'hFFF);
        end
      end
      CMD_LDR_LIT: begin
        if (d < 8 && si >= 0 && si <= 34'sd1020 && u[1:0] == 2'b0) begin
          h0 = 32'h4800 | (d << 8) | (u >> 2);
        end else begin
          two = 1'b1;
          ab = (si >= 0) ? si : -si;
          bad = ab > 34'sd4095;
          h0 = 32'hF85F | ((si >= 0) ? 32'h80 : 32'h0);
          h1 = (d << 12) | {20'h0, ab[11:0]};
        end
      end
      CMD_LDR_REG, CMD_LDRH_REG, CMD_STR_REG, CMD_STRH_REG: begin
        bad = d > 7 || n > 7 || m > 7;
        case (req.cmd)
          CMD_LDR_REG:  h0 = 32'h5800;
          CMD_LDRH_REG: h0 = 32'h5A00;
          CMD_STR_REG:  h0 = 32'h5000;
          default:      h0 = 32'h5200;
        endcase
        h0 = h0 | ((m & 7) << 6) | ((n & 7) << 3) | (d & 7);
      end
      CMD_LDRB_IMM, CMD_STRB_IMM: begin
        bad = u > 31 || n > 7 || d > 7;
        h0 = (req.cmd == CMD_LDRB_IMM ? 32'h7800 : 32'h7000) | ((u & 31) << 6) |
             ((n & 7) << 3) | (d & 7);
      end
      CMD_LDRH_IMM, CMD_STRH_IMM: begin
        if (d < 8 && n < 8 && (u & 32'hFFFFFFC1) == 0) begin
          h0 = (req.cmd == CMD_LDRH_IMM ? 32'h8800 : 32'h8000) | ((u >> 1) << 6) |
               (n << 3) | d;
        end else begin
          two = 1'b1;
          bad = n == 15 || u > 4095;
          h0 = (req.cmd == CMD_LDRH_IMM ? 32'hF8B0 : 32'hF8A0) | n;
          h1 = (d << 12) | (u & 32'hFFF);
        end
      end
      CMD_MOV_IMM: begin
        if (d < 8 && u <= 32'hFF) begin
          h0 = 32'h2000 | (d << 8) | u;
        end else if (mi.ok) begin
          two = 1'b1;
          h0 = 32'hF05F | (mi.e >> 16);
          h1 = (mi.e & 32'hFFFF) | (d << 8);
        end else begin
          two = 1'b1;
          bad = u > 32'hFFFF;
          h0 = 32'hF240 | ((w & 32'h800) >> 1) | (w >> 12);
          h1 = ((w & 32'h700) << 4) | (d << 8) | (w & 32'hFF);
        end
      end
      CMD_MOV_REG: begin
        if (!s[0]) h0 = 32'h4600 | ((d & 8) << 4) | (m << 3) | (d & 7);
        else if (d < 8 && m < 8) h0 = (m << 3) | d;
        else begin two = 1'b1; h0 = 32'hEA5F; h1 = (d << 8) | m; end
      end
      CMD_MOVT: begin
        two = 1'b1;
        bad = si < 0 || si > 34'sd65535;
        h0 = 32'hF2C0 | ((w & 32'h800) >> 1) | (w >> 12);
        h1 = ((w & 32'h700) << 4) | (d << 8) | (w & 32'hFF);
      end
      CMD_MRS: begin
        two = 1'b1;
        bad = si < 0 || si > 34'sd255;
        h0 = 32'hF3EF;
        h1 = 32'h8000 | (d << 8) | (u & 32'hFF);
      end
      CMD_MSR: begin
        two = 1'b1;
        bad = si < 0 || si > 34'sd255;
        h0 = 32'hF380 | n;
        h1 = 32'h8000 | ((rl & 3) << 10) | (u & 32'hFF);
      end
      CMD_MVN_IMM: begin
        two = 1'b1; bad = !mi.ok;
        h0 = 32'hF06F | (s << 4) | (e >> 16);
        h1 = (e & 32'hFFFF) | (d << 8);
      end
      CMD_NOP: h0 = 32'hBF00;
      CMD_POP_N: begin
        bad = rl > 32'hFF;
        h0 = 32'hBC00 | (fb << 8) | (rl & 32'hFF);
      end
      CMD_PUSH_N: begin
        bad = rl > 32'hFF;
        h0 = 32'hB400 | (fb << 8) | (rl & 32'hFF);
      end
      CMD_POP: begin
        bad = rl == 0;
        if ((rl & 32'h7F00) == 0) begin
          h0 = 32'hBC00 | ({31'h0, rl[15]} << 8) | (rl & 32'hFF);
        end else if ((rl & (rl - 1)) == 0) begin
          two = 1'b1; h0 = 32'hF85D; h1 = 32'h0B04 | ({27'h0, ctz32(rl)} << 12);
        end else begin
          two = 1'b1;
          bad = bad || rl[13] || rl[15:14] == 2'b11;
          h0 = 32'hE8BD; h1 = rl;
        end
      end
      CMD_PUSH: begin
        bad = rl == 0 || (rl & 32'hA000) != 0;
        if ((rl & 32'hBF00) == 0) begin
          h0 = 32'hB400 | ({31'h0, rl[14]} << 8) | (rl & 32'hFF);
        end else if ((rl & (rl - 1)) == 0) begin
          two = 1'b1; h0 = 32'hF84D; h1 = 32'h0D04 | ({27'h0, ctz32(rl)} << 12);
        end else begin
          two = 1'b1; h0 = 32'hE92D; h1 = rl;
        end
      end
      CMD_TST: begin
        if (lsl0 && n < 8 && m < 8) begin
          h0 = 32'h4200 | (m << 3) | n;
        end else begin
          two = 1'b1; bad = sh > 31;
          h0 = 32'hEA10 | n;
          h1 = 32'h0F00 | shvf | m;
        end
      end
      CMD_DATA: begin
        bad = si < 0 || si > 34'sd65535;
        h0 = w;
      end
      default: begin
        bad = 1'b1; h0 = 32'h0;
      end
    endcase
    enc.hw0 = h0[15:0];
    enc.hw1 = h1[15:0];
    enc.two = two;
    enc.bad = bad;
  end

endmodule

// File: hw/rtl/t2enc_back.sv
// Back end: serialises queued encodings into halfword transfers via an output register.
module t2enc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  t2enc_pkg::enc_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_halfword,
  output logic            out_last,
  output logic            out_bad_operand
);
  import t2enc_pkg::*;

  logic        vld_r, vld_nxt;
  logic        second_r, second_nxt;
  logic [15:0] hw_r, hw_nxt;
  logic        last_r, last_nxt;
  logic        bad_r, bad_nxt;
  logic        slot_free;

  // Output register is free when empty or being taken this cycle.
  assign slot_free = !vld_r || out_ready;
  // Entry is released once its final halfword has been loaded.
  assign q_ready   = slot_free && (!q_data.two || second_r);

  always_comb begin
    vld_nxt    = vld_r && !out_ready;
    second_nxt = second_r;
    hw_nxt     = hw_r;
    last_nxt   = last_r;
    bad_nxt    = bad_r;
    if (slot_free && q_valid) begin
      vld_nxt = 1'b1;
      bad_nxt = q_data.bad;
      if (q_data.two && !second_r) begin
        hw_nxt = q_data.hw0; last_nxt = 1'b0; second_nxt = 1'b1;
      end else if (q_data.two) begin
        hw_nxt = q_data.hw1; last_nxt = 1'b1; second_nxt = 1'b0;
      end else begin
        hw_nxt = q_data.hw0; last_nxt = 1'b1; second_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hw_r   <= hw_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid       = vld_r;
  assign out_halfword    = hw_r;
  assign out_last        = last_r;
  assign out_bad_operand = bad_r;

endmodule

// File: hw/rtl/thumb2_instruction_encoder.sv
// Thumb / Thumb-2 encoder top level: front end, two-entry queue, halfword back end.
// One request per input transfer becomes one or two halfword transfers, first halfword
// first, with last on the final one and bad_operand repeated on each. The front end
// encodes in the accept cycle and writes a two-entry queue; the back end emits one
// halfword per cycle while out_ready is high, through an output register, so a
// 32-bit instruction takes two transfers on the single halfword output port. A request
// passes through the queue and the output register before output. No configuration.
module thumb2_instruction_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_cmd,
  input  logic [3:0]  in_rd,
  input  logic [3:0]  in_rn,
  input  logic [3:0]  in_rm,
  input  logic signed [32:0] in_imm,
  input  logic        in_set_flags,
  input  logic [1:0]  in_shift_type,
  input  logic [5:0]  in_shift_amount,
  input  logic [3:0]  in_cond,
  input  logic [15:0] in_reg_list,
  input  logic        in_flag_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_halfword,
  output logic        out_last,
  output logic        out_bad_operand
);
  import t2enc_pkg::*;

  req_t req;
  enc_t q_data;
  logic q_valid, q_ready;

  always_comb begin
    req.cmd          = in_cmd;
    req.rd           = in_rd;
    req.rn           = in_rn;
    req.rm           = in_rm;
    req.imm          = in_imm;
    req.set_flags    = in_set_flags;
    req.shift_type   = in_shift_type;
    req.shift_amount = in_shift_amount;
    req.cond         = in_cond;
    req.reg_list     = in_reg_list;
    req.flag_bit     = in_flag_bit;
  end

  // Classification and encoding, queued.
  t2enc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  // Halfword serialiser.
  t2enc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_halfword(out_halfword),
    .out_last(out_last), .out_bad_operand(out_bad_operand)
  );

endmodule
